@@ src/cna_pkg.sv @@
// Package for the complex arithmetic unit: operation codes, payload types,
// widths and the fixed-point format. Depends on nothing.
`timescale 1ns / 1ps
package cna_pkg;
  localparam int unsigned DataW    = 32;
  localparam int unsigned FracBits = 16;
  localparam int unsigned KindW    = 3;
  localparam int unsigned ProdW    = 2 * DataW;
  localparam int unsigned SumW     = ProdW + 1;
  localparam int unsigned DenW     = ProdW + 1;
  localparam int unsigned NumW     = SumW + FracBits;
  localparam int unsigned QuoW     = 35;

  typedef enum logic [KindW-1:0] {
    KIND_ADD  = 3'd0,
    KIND_SUB  = 3'd1,
    KIND_MUL  = 3'd2,
    KIND_DIV  = 3'd3,
    KIND_CONJ = 3'd4
  } kind_e;

  typedef struct packed {
    logic [KindW-1:0]        kind;
    logic signed [DataW-1:0] a_real;
    logic signed [DataW-1:0] a_imag;
    logic signed [DataW-1:0] b_real;
    logic signed [DataW-1:0] b_imag;
  } req_t;

  typedef struct packed {
    logic signed [DataW-1:0] res_real;
    logic signed [DataW-1:0] res_imag;
    logic                    overflow;
    logic                    divide_by_zero;
  } rsp_t;
endpackage

@@ src/cna_stream_if.sv @@
// Valid/ready channel carrying one payload beat.
// Depends on cna_pkg for the payload types.
`timescale 1ns / 1ps
interface cna_req_if;
  logic          valid;
  logic          ready;
  cna_pkg::req_t data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

interface cna_rsp_if;
  logic          valid;
  logic          ready;
  cna_pkg::rsp_t data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

@@ src/complex_number_alu.sv @@
// Top level of the complex arithmetic unit: a pipelined datapath with a
// restoring divider laid out one quotient bit per stage.
// Depends on cna_pkg and the channel interfaces.
//
// Usage:
//   req_i carries kind and the operands a, b in signed Q16.16; rsp_o returns
//   res_real, res_imag, overflow and divide_by_zero, one beat per request, in
//   order. Every operation passes through the same 40 register stages,
//   3 + 36 + 1: a multiply stage, a sum stage, a normalise stage, one divider
//   stage per quotient bit (the quotient is capped at 35 bits after the
//   leading guard), and a saturation/output stage.
//   Throughput is one beat per cycle while the receiver does not stall.
//   The whole pipe advances when its output stage is empty or taken; when the
//   receiver stalls, all stages hold and req_i.ready drops, so nothing is
//   lost or repeated. Reset clears every valid bit; payloads are not reset.
`timescale 1ns / 1ps
module complex_number_alu (
  input  logic clk_i,
  input  logic rst_ni,
  cna_req_if.sink   req_i,
  cna_rsp_if.source rsp_o
);
  import cna_pkg::*;

  localparam int unsigned DivSteps = QuoW + 1;
  localparam int unsigned RemW     = DenW + 1;

  typedef struct packed {
    logic [KindW-1:0]        kind;
    logic signed [DataW:0]   add_re;
    logic signed [DataW:0]   add_im;
    logic signed [ProdW-1:0] p_rr;
    logic signed [ProdW-1:0] p_ii;
    logic signed [ProdW-1:0] p_ri;
    logic signed [ProdW-1:0] p_ir;
    logic signed [ProdW-1:0] p_bb_r;
    logic signed [ProdW-1:0] p_bb_i;
  } s1_t;

  typedef struct packed {
    logic [KindW-1:0]      kind;
    logic signed [DataW:0] add_re;
    logic signed [DataW:0] add_im;
    logic signed [SumW-1:0] sum_re;
    logic signed [SumW-1:0] sum_im;
    logic [DenW-1:0]       den;
  } s2_t;

  // divider lane: magnitude numerator is shifted in, quotient is built up
  typedef struct packed {
    logic [KindW-1:0]       kind;
    logic signed [DataW:0]  add_re;
    logic signed [DataW:0]  add_im;
    logic                   neg_re;
    logic                   neg_im;
    logic [NumW-1:0]        num_re;
    logic [NumW-1:0]        num_im;
    logic [RemW-1:0]        rem_re;
    logic [RemW-1:0]        rem_im;
    logic [QuoW:0]          quo_re;
    logic [QuoW:0]          quo_im;
    logic [DenW-1:0]        den;
    logic signed [QuoW+1:0] mul_re;
    logic signed [QuoW+1:0] mul_im;
  } sd_t;

  logic advance;
  logic s1_v_q, s2_v_q;
  s1_t  s1_q, s1_d;
  s2_t  s2_q, s2_d;
  logic [DivSteps:0] dv_v_q;
  sd_t  dv_q [DivSteps+1];
  sd_t  dv_d [DivSteps+1];
  logic out_v_q;
  rsp_t out_q, out_d;

  assign advance     = !out_v_q || rsp_o.ready;
  assign req_i.ready = advance;
  assign rsp_o.valid = out_v_q;
  assign rsp_o.data  = out_q;

  // stage 1: products and short sums
  always_comb begin
    s1_d.kind   = req_i.data.kind;
    s1_d.add_re = '0;
    s1_d.add_im = '0;
    case (req_i.data.kind)
      KIND_ADD: begin
        s1_d.add_re = {req_i.data.a_real[DataW-1], req_i.data.a_real}
                    + {req_i.data.b_real[DataW-1], req_i.data.b_real};
        s1_d.add_im = {req_i.data.a_imag[DataW-1], req_i.data.a_imag}
                    + {req_i.data.b_imag[DataW-1], req_i.data.b_imag};
      end
      KIND_SUB: begin
        s1_d.add_re = {req_i.data.a_real[DataW-1], req_i.data.a_real}
                    - {req_i.data.b_real[DataW-1], req_i.data.b_real};
        s1_d.add_im = {req_i.data.a_imag[DataW-1], req_i.data.a_imag}
                    - {req_i.data.b_imag[DataW-1], req_i.data.b_imag};
      end
      KIND_CONJ: begin
        s1_d.add_re = {req_i.data.a_real[DataW-1], req_i.data.a_real};
        s1_d.add_im = -{req_i.data.a_imag[DataW-1], req_i.data.a_imag};
      end
      default: ;
    endcase
    s1_d.p_rr   = ProdW'(req_i.data.a_real * req_i.data.b_real);
    s1_d.p_ii   = ProdW'(req_i.data.a_imag * req_i.data.b_imag);
    s1_d.p_ri   = ProdW'(req_i.data.a_real * req_i.data.b_imag);
    s1_d.p_ir   = ProdW'(req_i.data.a_imag * req_i.data.b_real);
    s1_d.p_bb_r = ProdW'(req_i.data.b_real * req_i.data.b_real);
    s1_d.p_bb_i = ProdW'(req_i.data.b_imag * req_i.data.b_imag);
  end

  // stage 2: cross sums and denominator
  always_comb begin
    s2_d.kind   = s1_q.kind;
    s2_d.add_re = s1_q.add_re;
    s2_d.add_im = s1_q.add_im;
    if (s1_q.kind == KIND_DIV) begin
      s2_d.sum_re = SumW'(s1_q.p_rr) + SumW'(s1_q.p_ii);
      s2_d.sum_im = SumW'(s1_q.p_ir) - SumW'(s1_q.p_ri);
    end else begin
      s2_d.sum_re = SumW'(s1_q.p_rr) - SumW'(s1_q.p_ii);
      s2_d.sum_im = SumW'(s1_q.p_ri) + SumW'(s1_q.p_ir);
    end
    s2_d.den = DenW'(unsigned'(s1_q.p_bb_r)) + DenW'(unsigned'(s1_q.p_bb_i));
  end

  // stage 3 (divider entry): sign-magnitude split and floor scaling
  function automatic logic signed [QuoW+1:0] floor_scale(logic signed [SumW-1:0] s);
    logic signed [SumW-1:0] sh;
    sh = s >>> FracBits;
    if (sh > SumW'(signed'({1'b0, {QuoW{1'b1}}})))
      return {2'b00, {QuoW{1'b1}}};
    else if (sh < -SumW'(signed'({1'b0, {QuoW{1'b1}}})))
      return -{2'b00, {QuoW{1'b1}}};
    return (QuoW+2)'(sh);
  endfunction

  always_comb begin
    logic [SumW-1:0] mre, mim;
    mre = s2_q.sum_re[SumW-1] ? SumW'(-s2_q.sum_re) : SumW'(s2_q.sum_re);
    mim = s2_q.sum_im[SumW-1] ? SumW'(-s2_q.sum_im) : SumW'(s2_q.sum_im);
    dv_d[0].kind   = s2_q.kind;
    dv_d[0].add_re = s2_q.add_re;
    dv_d[0].add_im = s2_q.add_im;
    dv_d[0].neg_re = s2_q.sum_re[SumW-1];
    dv_d[0].neg_im = s2_q.sum_im[SumW-1];
    dv_d[0].num_re = {mre, {FracBits{1'b0}}};
    dv_d[0].num_im = {mim, {FracBits{1'b0}}};
    dv_d[0].den    = s2_q.den;
    dv_d[0].mul_re = floor_scale(s2_q.sum_re);
    dv_d[0].mul_im = floor_scale(s2_q.sum_im);
    // partial remainder and quotient start at zero; the first divider step folds
    // the top of the numerator in with a saturating quotient head
    dv_d[0].rem_re = '0;
    dv_d[0].rem_im = '0;
    dv_d[0].quo_re = '0;
    dv_d[0].quo_im = '0;
  end

  // restoring divide step; the quotient saturates at the cap
  function automatic void div_step(input logic [RemW-1:0] rem, input logic [QuoW:0] quo,
                                   input logic bit_in, input logic [DenW-1:0] den,
                                   output logic [RemW-1:0] rem_n,
                                   output logic [QuoW:0] quo_n);
    logic [RemW-1:0] r;
    r = {rem[RemW-2:0], bit_in};
    if (r >= RemW'(den)) begin
      rem_n = r - RemW'(den);
      quo_n = {quo[QuoW-1:0], 1'b1};
    end else begin
      rem_n = r;
      quo_n = {quo[QuoW-1:0], 1'b0};
    end
    if (quo[QuoW] || quo[QuoW-1]) quo_n = {1'b1, {QuoW{1'b0}}};
  endfunction

  // the leading NumW-DivSteps numerator bits are handled in a prologue: the
  // quotient for those is either zero or already past the cap
  localparam int unsigned HeadW = NumW - DivSteps;

  for (genvar g = 1; g <= DivSteps; g++) begin : g_div
    always_comb begin
      logic [RemW-1:0] rr, ri;
      logic [QuoW:0]   qr, qi;
      dv_d[g] = dv_q[g-1];
      if (g == 1) begin
        rr = RemW'(dv_q[0].num_re[NumW-1 -: HeadW]);
        ri = RemW'(dv_q[0].num_im[NumW-1 -: HeadW]);
        qr = (rr >= RemW'(dv_q[0].den)) ? {1'b1, {QuoW{1'b0}}} : '0;
        qi = (ri >= RemW'(dv_q[0].den)) ? {1'b1, {QuoW{1'b0}}} : '0;
      end else begin
        rr = dv_q[g-1].rem_re;
        ri = dv_q[g-1].rem_im;
        qr = dv_q[g-1].quo_re;
        qi = dv_q[g-1].quo_im;
      end
      div_step(rr, qr, dv_q[g-1].num_re[DivSteps-g], dv_q[g-1].den,
               dv_d[g].rem_re, dv_d[g].quo_re);
      div_step(ri, qi, dv_q[g-1].num_im[DivSteps-g], dv_q[g-1].den,
               dv_d[g].rem_im, dv_d[g].quo_im);
    end
  end

  // output stage: select, saturate, flag
  function automatic logic signed [DataW-1:0] sat(logic signed [QuoW+1:0] v,
                                                  output logic ov);
    ov = 1'b0;
    if (v > (QuoW+2)'(signed'({1'b0, {(DataW-1){1'b1}}}))) begin
      ov = 1'b1;
      return {1'b0, {(DataW-1){1'b1}}};
    end
    if (v < -(QuoW+2)'(signed'({1'b0, {(DataW-1){1'b1}}})) - 1) begin
      ov = 1'b1;
      return {1'b1, {(DataW-1){1'b0}}};
    end
    return DataW'(v);
  endfunction

  always_comb begin
    sd_t t;
    logic ov_r, ov_i;
    logic signed [QuoW+1:0] vr, vi;
    logic [QuoW:0] qr, qi;
    t  = dv_q[DivSteps];
    qr = t.quo_re[QuoW] ? {1'b0, 1'b1, {(QuoW-1){1'b0}}} : t.quo_re;
    qi = t.quo_im[QuoW] ? {1'b0, 1'b1, {(QuoW-1){1'b0}}} : t.quo_im;
    vr = '0;
    vi = '0;
    out_d = '0;
    case (t.kind)
      KIND_ADD, KIND_SUB, KIND_CONJ: begin
        vr = (QuoW+2)'(t.add_re);
        vi = (QuoW+2)'(t.add_im);
      end
      KIND_MUL: begin
        vr = t.mul_re;
        vi = t.mul_im;
      end
      KIND_DIV: begin
        vr = t.neg_re ? -signed'({1'b0, qr}) : signed'({1'b0, qr});
        vi = t.neg_im ? -signed'({1'b0, qi}) : signed'({1'b0, qi});
      end
      default: ;
    endcase
    out_d.res_real = sat(vr, ov_r);
    out_d.res_imag = sat(vi, ov_i);
    out_d.overflow = ov_r | ov_i;
    if (t.kind == KIND_DIV && t.den == '0) begin
      out_d.res_real       = '0;
      out_d.res_imag       = '0;
      out_d.overflow       = 1'b0;
      out_d.divide_by_zero = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_v_q  <= 1'b0;
      s2_v_q  <= 1'b0;
      dv_v_q  <= '0;
      out_v_q <= 1'b0;
    end else if (advance) begin
      s1_v_q  <= req_i.valid;
      s2_v_q  <= s1_v_q;
      dv_v_q  <= {dv_v_q[DivSteps-1:0], s2_v_q};
      out_v_q <= dv_v_q[DivSteps];
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      s1_q  <= s1_d;
      s2_q  <= s2_d;
      out_q <= out_d;
      for (int k = 0; k <= DivSteps; k++) dv_q[k] <= dv_d[k];
    end
  end
endmodule

@@ src/cna_checker.sv @@
// Port-level checks for the complex arithmetic unit, bound to the top level.
// Depends on cna_pkg and complex_number_alu.
`timescale 1ns / 1ps
module cna_checker (
  input logic          clk_i,
  input logic          rst_ni,
  input logic          in_valid_i,
  input logic          in_ready_i,
  input logic          out_valid_i,
  input logic          out_ready_i,
  input cna_pkg::rsp_t out_data_i
);
  import cna_pkg::*;

  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i && $stable(out_data_i))
    else $error("stalled beat changed");

  a_ready: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !out_valid_i |-> in_ready_i)
    else $error("input blocked with empty output");

  a_flags: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && out_data_i.divide_by_zero |->
      !out_data_i.overflow && out_data_i.res_real == '0 && out_data_i.res_imag == '0)
    else $error("zero divisor result not cleared");

  a_stall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |-> !in_ready_i)
    else $error("input taken during stall");
endmodule

bind complex_number_alu cna_checker u_cna_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (req_i.valid),
  .in_ready_i  (req_i.ready),
  .out_valid_i (rsp_o.valid),
  .out_ready_i (rsp_o.ready),
  .out_data_i  (rsp_o.data)
);

@@ test/tb_complex_number_alu.sv @@
// Self-checking testbench for the complex arithmetic unit: drives random and
// corner-case requests through the valid/ready channels and checks each beat.
// Depends on cna_pkg, the channel interfaces and complex_number_alu.
`timescale 1ns / 1ps
module tb_complex_number_alu;
  import cna_pkg::*;

  localparam int unsigned WatchLimit = 4000;
  localparam int unsigned Drain      = 60;

  logic clk_i = 1'b0;
  logic rst_ni;

  cna_req_if req_if ();
  cna_rsp_if rsp_if ();

  complex_number_alu uut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (req_if),
    .rsp_o  (rsp_if)
  );

  rsp_t        expected_q[$];
  int unsigned errors;
  int unsigned sent;
  int unsigned checked;
  int unsigned send_idle;
  int unsigned recv_idle;
  int unsigned quiet;
  int unsigned kind_seen[8];

  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  function automatic logic [31:0] sat32(input logic signed [127:0] v, inout logic ov);
    if (v > 128'sh7FFF_FFFF) begin
      ov = 1'b1;
      return 32'h7FFF_FFFF;
    end
    if (v < -128'sh8000_0000) begin
      ov = 1'b1;
      return 32'h8000_0000;
    end
    return v[31:0];
  endfunction

  // floor division by 2^FracBits
  function automatic logic signed [127:0] scale_down(input logic signed [127:0] s);
    return s >>> FracBits;
  endfunction

  // quotient rounded toward zero
  function automatic logic signed [127:0] div_toward_zero(input logic signed [127:0] num,
                                                          input logic signed [127:0] den);
    logic        neg;
    logic [127:0] mag;
    neg = num < 0;
    mag = neg ? -num : num;
    mag = (mag << FracBits) / den;
    return neg ? -$signed(mag) : $signed(mag);
  endfunction

  function automatic rsp_t complex_result(input req_t r);
    rsp_t o;
    logic signed [127:0] ar, ai, br, bi, den;
    logic ov;
    ar = r.a_real;
    ai = r.a_imag;
    br = r.b_real;
    bi = r.b_imag;
    ov = 1'b0;
    o  = '0;
    case (r.kind)
      KIND_ADD: begin
        o.res_real = sat32(ar + br, ov);
        o.res_imag = sat32(ai + bi, ov);
      end
      KIND_SUB: begin
        o.res_real = sat32(ar - br, ov);
        o.res_imag = sat32(ai - bi, ov);
      end
      KIND_MUL: begin
        o.res_real = sat32(scale_down(ar * br - ai * bi), ov);
        o.res_imag = sat32(scale_down(ar * bi + ai * br), ov);
      end
      KIND_DIV: begin
        den = br * br + bi * bi;
        if (den == 0) begin
          o.divide_by_zero = 1'b1;
        end else begin
          o.res_real = sat32(div_toward_zero(ar * br + ai * bi, den), ov);
          o.res_imag = sat32(div_toward_zero(ai * br - ar * bi, den), ov);
        end
      end
      KIND_CONJ: begin
        o.res_real = sat32(ar, ov);
        o.res_imag = sat32(-ai, ov);
      end
      default: ;
    endcase
    o.overflow = ov;
    return o;
  endfunction

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    errors++;
    $display("mismatch on beat %0d: %s got %h want %h", checked, what, got, want);
  endtask

  // result checker
  always @(posedge clk_i) begin
    if (rst_ni && rsp_if.valid && rsp_if.ready) begin
      if (expected_q.size() == 0) begin
        report_mismatch("unexpected beat", rsp_if.data.res_real, 32'h0);
      end else begin
        rsp_t want;
        want = expected_q.pop_front();
        if (rsp_if.data.res_real !== want.res_real)
          report_mismatch("res_real", rsp_if.data.res_real, want.res_real);
        if (rsp_if.data.res_imag !== want.res_imag)
          report_mismatch("res_imag", rsp_if.data.res_imag, want.res_imag);
        if (rsp_if.data.overflow !== want.overflow)
          report_mismatch("overflow", 32'(rsp_if.data.overflow), 32'(want.overflow));
        if (rsp_if.data.divide_by_zero !== want.divide_by_zero)
          report_mismatch("divide_by_zero", 32'(rsp_if.data.divide_by_zero),
                          32'(want.divide_by_zero));
      end
      checked++;
    end
  end

  // receiver stalls
  always @(posedge clk_i) begin
    if (!rst_ni) rsp_if.ready <= 1'b0;
    else rsp_if.ready <= ($urandom_range(99) >= recv_idle);
  end

  // watchdog on accepted beats
  always @(posedge clk_i) begin
    if ((req_if.valid && req_if.ready) || (rsp_if.valid && rsp_if.ready)) begin
      quiet <= 0;
    end else if (rst_ni) begin
      quiet <= quiet + 1;
      if (quiet >= WatchLimit) begin
        $display("watchdog expired");
        $display("RESULT: ERROR");
        $finish;
      end
    end
  end

  task automatic send_beat(input req_t r);
    while ($urandom_range(99) < send_idle) begin
      req_if.valid <= 1'b0;
      @(posedge clk_i);
    end
    req_if.valid <= 1'b1;
    req_if.data  <= r;
    do @(posedge clk_i); while (!req_if.ready);
    expected_q.push_back(complex_result(r));
    kind_seen[r.kind]++;
    sent++;
  endtask

  function automatic logic [31:0] edge_value();
    case ($urandom_range(7))
      0: return 32'h8000_0000;
      1: return 32'h7FFF_FFFF;
      2: return 32'h0;
      3: return 32'hFFFF_FFFF;
      4: return 32'h0001_0000;
      5: return 32'hFFFF_0000;
      6: return $urandom_range(32'h3_FFFF) - 32'h2_0000;
      default: return $urandom();
    endcase
  endfunction

  function automatic req_t make_req(input logic [2:0] kind, input logic [31:0] ar,
                                    input logic [31:0] ai, input logic [31:0] br,
                                    input logic [31:0] bi);
    req_t r;
    r.kind   = kind;
    r.a_real = ar;
    r.a_imag = ai;
    r.b_real = br;
    r.b_imag = bi;
    return r;
  endfunction

  task automatic test_corners();
    kind_e k;
    k = k.first();
    do begin
      send_beat(make_req(k, 32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000));
      send_beat(make_req(k, 32'h8000_0000, 32'h7FFF_FFFF, 32'h0001_0000, 32'hFFFF_FFFF));
      k = k.next();
    end while (k != k.first());
    send_beat(make_req(KIND_DIV, 32'h0003_0000, 32'h0001_0000, 32'h0, 32'h0));
    send_beat(make_req(KIND_DIV, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h0, 32'h1));
    send_beat(make_req(KIND_DIV, 32'hFFFF_FFFF, 32'h0, 32'h0003_0000, 32'h0));
    send_beat(make_req(KIND_MUL, 32'hFFFF_FFFF, 32'h0, 32'h0000_0001, 32'h0));
    send_beat(make_req(KIND_CONJ, 32'h1234_5678, 32'h8000_0000, 32'h0, 32'h0));
    send_beat(make_req(3'd5, 32'h1, 32'h2, 32'h3, 32'h4));
    send_beat(make_req(3'd6, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF));
    send_beat(make_req(3'd7, 32'h8000_0000, 32'h0, 32'h0, 32'h0));
  endtask

  task automatic test_random(input int unsigned count);
    logic [2:0] k;
    repeat (count) begin
      k = ($urandom_range(19) == 0) ? 3'($urandom_range(7, 5)) : 3'($urandom_range(4));
      if ($urandom_range(1))
        send_beat(make_req(k, edge_value(), edge_value(), edge_value(), edge_value()));
      else
        send_beat(make_req(k, $urandom(), $urandom(), $urandom(), $urandom()));
    end
  endtask

  task automatic run_phase(input int unsigned s_idle, input int unsigned r_idle,
                           input int unsigned count);
    send_idle = s_idle;
    recv_idle = r_idle;
    test_random(count);
  endtask

  initial begin
    sent         = 0;
    send_idle    = 0;
    recv_idle    = 0;
    foreach (kind_seen[i]) kind_seen[i] = 0;
    req_if.valid = 1'b0;
    req_if.data  = '0;
    rst_ni       = 1'b0;
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    run_phase(24, 48, 180);
    run_phase(48, 24, 180);
    run_phase(0, 0, 170);
    test_corners();
    req_if.valid <= 1'b0;
    while (expected_q.size() != 0) @(posedge clk_i);
    repeat (Drain) @(posedge clk_i);
    $display("sent %0d requests, checked %0d results", sent, checked);
    $display("add %0d sub %0d mul %0d div %0d conj %0d unused %0d", kind_seen[0],
             kind_seen[1], kind_seen[2], kind_seen[3], kind_seen[4],
             kind_seen[5] + kind_seen[6] + kind_seen[7]);
    if (errors == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end
endmodule
